// File: rtl/intra_reference_sample_prepare_assert.svh
// Assertion macros for the intra reference sample preparation block
`ifndef INTRA_REFERENCE_SAMPLE_PREPARE_ASSERT_SVH
`define INTRA_REFERENCE_SAMPLE_PREPARE_ASSERT_SVH
// Implication checked every clock edge outside reset
`define IRSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irsp check failed");
// Implication checked in the cycle after the antecedent
`define IRSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irsp check failed");
`endif

// File: rtl/irsp_pkg.sv
// Package for the intra reference sample preparation block
`timescale 1ns / 1ps
`default_nettype none
package irsp_pkg;
  localparam int MAX_BLOCK_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STRONG_SIZE     = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 5;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_EN  = 2'd3;
endpackage
`default_nettype wire

// File: rtl/irsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module irsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 129
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/intra_reference_sample_prepare.sv
// Top level: loads a reference line, substitutes gaps, smooths and streams it out
//
// channel | dir | transfer
// in_*    | in  | one neighbour sample per transfer, tlast on the final one
// out_*   | out | four plain and four smoothed samples per transfer
// cfg_*   | in  | register write, one per clock, no read-back
//
// Loading takes a sample on every valid transfer. After the last sample, a scan pass
// (one RAM read per cycle) finds the first available sample, a substitution pass
// rebuilds the line into a second RAM, a single state picks the filter, then an
// output pass fills a window of three and gathers four lanes per result to stream
// it, each result holding until it is taken; each RAM has a single read port.
// Input is not ready during the passes.
// Reset (rst_n low, synchronous) clears the sequencer, counters and configuration registers.
// A stalled output holds its transfer; the pass waits on out_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "intra_reference_sample_prepare_assert.svh"
module intra_reference_sample_prepare
  import irsp_pkg::*;
#(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: sample_value [SAMPLE_BITS-1:0]
  input  wire logic [15:0]           in_tdata,
  // tuser: sample_available
  input  wire logic                  in_tuser,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata: first_index[7:0], plain_lane0..3 (16 each), smooth_lane0..3 (16 each)
  output logic [135:0]               out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int DEPTH = 4 * MAX_BLOCK + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LGMAX = $clog2(MAX_BLOCK);
  localparam int SW    = SAMPLE_BITS;
  localparam int PW    = SW + LGMAX + 3;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_SUB, ST_STRONG, ST_OUT, ST_HOLD
  } state_t;

  state_t            state_r;
  logic [4:0]        bit_depth_r;
  logic [2:0]        log2_r;
  logic              filt_r, strong_en_r;
  logic [CW-1:0]     load_cnt_r;
  logic [CW-1:0]     pos_r;
  logic              any_r;
  logic [SW-1:0]     prev_r;
  logic [SW-1:0]     bl_r, tl_r, tr_r, mid_l_r, mid_t_r;
  logic              strong_r;
  logic [SW-1:0]     win_r [3];
  logic [1:0]        lane_r;
  logic [SW-1:0]     pl_r [4];
  logic [SW-1:0]     sm_r [4];
  logic [7:0]        base_r;
  logic              out_v_r, out_last_r;

  // effective configuration
  logic [2:0]    lg;
  logic [4:0]    bd;
  logic [CW-1:0] total, n_c, n2_c, loaded;
  always_comb begin
    lg = (log2_r < 3'd2) ? 3'd2 : ((32'(log2_r) > LGMAX) ? 3'(LGMAX) : log2_r);
    bd = (bit_depth_r < 5'd8) ? 5'd8 : ((32'(bit_depth_r) > SW) ? 5'(SW) : bit_depth_r);
    n_c    = CW'(1) << lg;
    n2_c   = n_c << 1;
    total  = (n_c << 2) + CW'(1);
    loaded = (load_cnt_r < total) ? load_cnt_r : total;
  end

  // raw sample store and flags
  logic          raw_we;
  logic [AW-1:0] raw_ra;
  logic [SW:0]   raw_rd;
  assign raw_we = in_tvalid && in_tready && (load_cnt_r < CW'(DEPTH));
  irsp_ram #(.WIDTH(SW + 1), .DEPTH(DEPTH)) u_raw (
    .clk(clk), .wr_en(raw_we), .wr_addr(load_cnt_r[AW-1:0]),
    .wr_data({in_tuser, in_tdata[SW-1:0]}), .rd_addr(raw_ra), .rd_data(raw_rd)
  );

  // substituted line store
  logic          ln_we;
  logic [AW-1:0] ln_wa, ln_ra;
  logic [SW-1:0] ln_wd, ln_rd;
  irsp_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_line (
    .clk(clk), .wr_en(ln_we), .wr_addr(ln_wa), .wr_data(ln_wd),
    .rd_addr(ln_ra), .rd_data(ln_rd)
  );

  assign in_tready = (state_r == ST_LOAD);
  assign raw_ra    = pos_r[AW-1:0];

  // scan and substitution datapath
  logic [CW-1:0] rpos;       // position whose raw read is in raw_rd
  logic          r_ok;
  logic [SW-1:0] sub_val;
  logic [SW-1:0] grey;
  assign rpos  = pos_r - CW'(1);
  assign r_ok  = (rpos < loaded) && raw_rd[SW];
  assign grey  = SW'(1) << (bd - 5'd1);
  always_comb begin
    if (!any_r)        sub_val = grey;
    else if (r_ok)     sub_val = raw_rd[SW-1:0];
    else if (rpos == '0) sub_val = prev_r;
    else               sub_val = prev_r;
  end
  assign ln_we = (state_r == ST_SUB) && (pos_r != '0);
  assign ln_wa = rpos[AW-1:0];
  assign ln_wd = sub_val;

  // absolute flatness checks for the left and top halves; the bilinear product follows per lane
  logic [SW+1:0] fl_sum, fl_two, fl_diff;
  logic          flat_l, flat_t;
  logic [SW+1:0] thr;
  assign thr    = (SW+2)'(1) << (bd - 5'd5);
  assign fl_sum = (SW+2)'(bl_r) + (SW+2)'(tl_r);
  assign fl_two = (SW+2)'(mid_l_r) << 1;
  assign fl_diff = (fl_sum > fl_two) ? fl_sum - fl_two : fl_two - fl_sum;
  assign flat_l = fl_diff < thr;
  logic [SW+1:0] ft_sum, ft_two, ft_diff;
  assign ft_sum = (SW+2)'(tl_r) + (SW+2)'(tr_r);
  assign ft_two = (SW+2)'(mid_t_r) << 1;
  assign ft_diff = (ft_sum > ft_two) ? ft_sum - ft_two : ft_two - ft_sum;
  assign flat_t = ft_diff < thr;

  // output pass: the sample in ln_rd sits at position q = pos_r - 1
  logic [CW-1:0] q;
  logic [CW-1:0] sp;         // position being smoothed (q - 2)
  logic [SW-1:0] smooth_v;
  logic [CW-1:0] off;
  logic [SW-1:0] ea, eb;
  logic [PW-1:0] prod;
  assign q  = pos_r - CW'(1);
  assign sp = q - CW'(2);
  // keep reading position q while a transfer waits
  assign ln_ra = (state_r == ST_HOLD) ? q[AW-1:0] : pos_r[AW-1:0];
  always_comb begin
    if (sp < n2_c) begin
      off = sp; ea = bl_r; eb = tl_r;
    end else begin
      off = sp - n2_c; ea = tl_r; eb = tr_r;
    end
    prod = PW'((PW'(n2_c - off) * PW'(ea) + PW'(off) * PW'(eb) + PW'(n_c)) >> (lg + 3'd1));
  end
  logic [SW+1:0] tap_sum;
  assign tap_sum = (SW+2)'(win_r[0]) + ((SW+2)'(win_r[1]) << 1) + (SW+2)'(win_r[2])
                 + (SW+2)'(2);
  always_comb begin
    if (!filt_r || sp == '0 || sp == total - CW'(1)) smooth_v = win_r[1];
    else if (strong_r)  smooth_v = (off == '0) ? ea : prod[SW-1:0];
    else                smooth_v = tap_sum[SW+1:2];
  end
  logic [SW-1:0] next_tap;   // sample at position q, clamped to the line
  assign next_tap = (q < total) ? ln_rd : win_r[2];

  logic out_fire;
  assign out_fire = out_v_r && out_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      bit_depth_r <= 5'd8;
      log2_r      <= 3'd2;
      filt_r      <= 1'b0;
      strong_en_r <= 1'b0;
      load_cnt_r  <= '0;
      pos_r       <= '0;
      any_r       <= 1'b0;
      out_v_r     <= 1'b0;
      lane_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BIT_DEPTH:  bit_depth_r <= cfg_wdata;
          REG_BLOCK_LOG2: log2_r      <= cfg_wdata[2:0];
          REG_FILTER_EN:  filt_r      <= cfg_wdata[0];
          REG_STRONG_EN:  strong_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_tvalid) begin
            if (load_cnt_r < CW'(DEPTH)) load_cnt_r <= load_cnt_r + CW'(1);
            if (in_tlast) begin
              state_r <= ST_SCAN;
              pos_r   <= '0;
              any_r   <= 1'b0;
            end
          end
        end
        // find the first available sample: read at pos_r, judge at pos_r-1
        ST_SCAN: begin
          if (pos_r != '0 && r_ok && !any_r) begin
            any_r  <= 1'b1;
            prev_r <= raw_rd[SW-1:0];
          end
          if (pos_r == total) begin
            state_r <= ST_SUB;
            pos_r   <= '0;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        // rebuild the line; prev starts at the first available sample
        ST_SUB: begin
          if (pos_r != '0) begin
            prev_r <= sub_val;
            if (rpos == '0) bl_r <= sub_val;
            if (rpos == n_c) mid_l_r <= sub_val;
            if (rpos == n2_c) tl_r <= sub_val;
            if (rpos == n2_c + n_c) mid_t_r <= sub_val;
            if (rpos == total - CW'(1)) tr_r <= sub_val;
          end
          if (pos_r == total) begin
            state_r <= ST_STRONG;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        ST_STRONG: begin
          strong_r <= filt_r && strong_en_r && (n_c == CW'(STRONG_SIZE)) && flat_l && flat_t;
          state_r  <= ST_OUT;
          pos_r    <= '0;
          lane_r   <= '0;
          base_r   <= '0;
        end
        // stream: window of three, one sample per cycle outside the hold state, four per transfer
        ST_OUT: begin
          if (pos_r == '0) begin
            pos_r <= CW'(1);
          end else begin
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2] <= next_tap;
            if (pos_r >= CW'(3)) begin
              pl_r[lane_r] <= (sp < total) ? win_r[1] : '0;
              sm_r[lane_r] <= (sp < total) ? smooth_v : '0;
              lane_r <= lane_r + 2'd1;
              if (lane_r == 2'd3) begin
                out_v_r    <= 1'b1;
                out_last_r <= (sp + CW'(1) >= total);
                state_r    <= ST_HOLD;
              end
            end
            pos_r <= pos_r + CW'(1);
          end
        end
        ST_HOLD: begin
          if (out_fire) begin
            out_v_r <= 1'b0;
            if (out_last_r) begin
              state_r    <= ST_LOAD;
              load_cnt_r <= '0;
            end else begin
              state_r <= ST_OUT;
              base_r  <= base_r + 8'd4;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {16'(sm_r[3]), 16'(sm_r[2]), 16'(sm_r[1]), 16'(sm_r[0]),
                       16'(pl_r[3]), 16'(pl_r[2]), 16'(pl_r[1]), 16'(pl_r[0]), base_r};

  `IRSP_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_r != ST_LOAD, !in_tready)
  `IRSP_ASSERT_IMP(a_out_only_hold, clk, rst_n, out_tvalid, state_r == ST_HOLD)
  `IRSP_ASSERT_NEXT(a_last_to_load, clk, rst_n, out_fire && out_tlast, state_r == ST_LOAD)
endmodule
`default_nettype wire

// File: bench/intra_reference_sample_prepare_tb.sv
// Testbench for the intra reference sample preparation block
`timescale 1ns / 1ps
module intra_reference_sample_prepare_tb;
  import irsp_pkg::*;

  typedef struct {
    logic [15:0] value;
    logic        avail;
    logic        last;
  } sample_t;

  typedef struct {
    logic [7:0]  first_index;
    logic [15:0] plain [4];
    logic [15:0] smooth [4];
    logic        last;
  } chunk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  intra_reference_sample_prepare DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow registers and line store of the predictor
  logic [4:0] sh_depth = 5'd8;
  logic [2:0] sh_log2 = 3'd2;
  logic sh_filter = 1'b0;
  logic sh_strong = 1'b0;
  logic [15:0] line_store [129];
  logic line_flag [129];
  int load_cnt = 0;

  sample_t pending_samples[$];
  chunk_t expected_chunks[$];
  int pushed_total = 0;
  int taken_total = 0;
  int fail_count = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int burst_left = 1;
  logic in_took = 1'b0;

  // Build the substituted and smoothed line, queue the expected transfers
  task automatic predict_line();
    int lg, n, n2, total, bd, loaded, first, i, k, thr, sh;
    bit any, use_strong;
    int plain [129];
    int smooth [129];
    chunk_t c;
    lg = sh_log2;
    if (lg < 2) lg = 2;
    if (lg > 5) lg = 5;
    n = 1 << lg;
    n2 = 2 * n;
    total = 4 * n + 1;
    bd = sh_depth;
    if (bd < 8) bd = 8;
    if (bd > 16) bd = 16;
    loaded = load_cnt < total ? load_cnt : total;
    any = 0;
    first = 0;
    for (i = 0; i < loaded; i++)
      if (line_flag[i] && !any) begin
        any = 1;
        first = i;
      end
    if (!any) begin
      for (i = 0; i < total; i++) plain[i] = 1 << (bd - 1);
    end else begin
      plain[0] = line_store[first];
      for (i = 0; i < total; i++)
        if (i < loaded && line_flag[i]) plain[i] = line_store[i];
        else if (i > 0) plain[i] = plain[i-1];
    end
    for (i = 0; i < total; i++) smooth[i] = plain[i];
    if (sh_filter) begin
      thr = 1 << (bd - 5);
      use_strong = sh_strong && n == STRONG_SIZE
        && ((plain[0] + plain[n2] - 2 * plain[n]) < thr)
        && ((2 * plain[n] - plain[0] - plain[n2]) < thr)
        && ((plain[n2] + plain[total-1] - 2 * plain[n2+n]) < thr)
        && ((2 * plain[n2+n] - plain[n2] - plain[total-1]) < thr);
      if (use_strong) begin
        sh = lg + 1;
        for (i = 1; i < n2; i++) begin
          smooth[i] = ((n2 - i) * plain[0] + i * plain[n2] + n) >> sh;
          smooth[n2+i] = ((n2 - i) * plain[n2] + i * plain[total-1] + n) >> sh;
        end
      end else begin
        for (i = 1; i + 1 < total; i++)
          smooth[i] = (plain[i-1] + 2 * plain[i] + plain[i+1] + 2) >> 2;
      end
    end
    for (i = 0; i < total; i += 4) begin
      c.first_index = i[7:0];
      for (k = 0; k < 4; k++) begin
        c.plain[k] = (i + k < total) ? plain[i+k][15:0] : 16'd0;
        c.smooth[k] = (i + k < total) ? smooth[i+k][15:0] : 16'd0;
      end
      c.last = (i + 4 >= total);
      expected_chunks.push_back(c);
    end
  endtask

  // Sender: bursts of transfers with random gaps
  always @(negedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= s.value;
        in_tuser <= s.avail;
        in_tlast <= s.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Track accepted samples and check result transfers
  always @(posedge clk) begin
    chunk_t c;
    int k;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chunks.size() == 0) begin
        $error("unexpected result transfer, first_index %0d", out_tdata[7:0]);
        fail_count++;
      end else begin
        c = expected_chunks.pop_front();
        if (out_tdata[7:0] !== c.first_index) begin
          $error("first_index expected %0d got %0d", c.first_index, out_tdata[7:0]);
          fail_count++;
        end
        for (k = 0; k < 4; k++) begin
          if (out_tdata[8+16*k +: 16] !== c.plain[k]) begin
            $error("plain_lane%0d expected %0h got %0h", k, c.plain[k],
                   out_tdata[8+16*k +: 16]);
            fail_count++;
          end
          if (out_tdata[72+16*k +: 16] !== c.smooth[k]) begin
            $error("smooth_lane%0d expected %0h got %0h", k, c.smooth[k],
                   out_tdata[72+16*k +: 16]);
            fail_count++;
          end
        end
        if (out_tlast !== c.last) begin
          $error("result_last expected %0d got %0d", c.last, out_tlast);
          fail_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      taken_total++;
      if (load_cnt < 129) begin
        line_store[load_cnt] = in_tdata;
        line_flag[load_cnt] = in_tuser;
        load_cnt++;
      end
      if (in_tlast) begin
        predict_line();
        load_cnt = 0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_BIT_DEPTH:  sh_depth = val[4:0];
      REG_BLOCK_LOG2: sh_log2 = val[2:0];
      REG_FILTER_EN:  sh_filter = val[0];
      REG_STRONG_EN:  sh_strong = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int depth, input int lg, input int flt, input int strg);
    write_reg(REG_BIT_DEPTH, depth);
    write_reg(REG_BLOCK_LOG2, lg);
    write_reg(REG_FILTER_EN, flt);
    write_reg(REG_STRONG_EN, strg);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_sample(input int value, input bit avail, input bit last);
    sample_t s;
    s.value = value[15:0];
    s.avail = avail;
    s.last = last;
    pending_samples.push_back(s);
    pushed_total++;
  endtask

  // One sample set; style: 0 random gaps, 1 none available, 2 ramp for strong
  // smoothing, 3 full-range noise, 4 all available at full scale
  task automatic push_set(input int len, input int style);
    int i, bd, vmax, a, b, m, v, p;
    bd = sh_depth < 8 ? 8 : (sh_depth > 16 ? 16 : sh_depth);
    vmax = (1 << bd) - 1;
    a = $urandom_range(0, vmax);
    b = $urandom_range(0, vmax);
    m = $urandom_range(0, vmax);
    p = $urandom_range(0, 100);
    for (i = 0; i < len; i++) begin
      case (style)
        1: push_sample($urandom_range(0, 65535), 1'b0, i == len - 1);
        2: begin
          v = (i <= 64) ? a + ((m - a) * i) / 64 : m + ((b - m) * (i - 64)) / 64;
          push_sample(v, 1'b1, i == len - 1);
        end
        3: push_sample($urandom_range(0, 65535), $urandom_range(0, 1), i == len - 1);
        4: push_sample(65535, 1'b1, i == len - 1);
        default: push_sample($urandom_range(0, vmax), $urandom_range(0, 99) < p,
                             i == len - 1);
      endcase
    end
  endtask

  task automatic wait_idle();
    while (taken_total != pushed_total || expected_chunks.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic int set_len();
    int lg;
    lg = sh_log2 < 2 ? 2 : (sh_log2 > 5 ? 5 : sh_log2);
    return 4 * (1 << lg) + 1;
  endfunction

  initial begin
    int ph, s, len, r;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: reset settings, then extremes and special cases
    push_set(17, 1);
    push_set(17, 4);
    wait_idle();
    configure(16, 2, 1, 1);
    push_sample(0, 0, 0); push_sample(0, 0, 0); push_sample(1234, 1, 0);
    for (s = 0; s < 13; s++) push_sample(s * 4000, s % 3 == 0, 0);
    push_sample(65535, 0, 1);
    push_sample(500, 1, 0); push_sample(9, 1, 1);
    wait_idle();
    configure(0, 0, 1, 0);
    push_set(20, 3);
    wait_idle();
    configure(31, 7, 1, 1);
    push_set(129, 2);
    stall_pct = 60;
    wait_idle();
    // Random phases, small blocks
    for (ph = 0; ph < 3; ph++) begin
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(10, 80);
      configure($urandom_range(0, 31), $urandom_range(0, 3),
                $urandom_range(0, 1), $urandom_range(0, 1));
      for (s = 0; s < 2; s++) begin
        len = set_len();
        r = $urandom_range(0, 19);
        if (r == 0) push_set($urandom_range(1, len - 1), 0);
        else if (r == 1) push_set(len + $urandom_range(1, 6), 3);
        else if (r == 2) push_set(len, 1);
        else if (r == 3) push_set(len, 3);
        else push_set(len, 0);
      end
      wait_idle();
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
